### sv/c3sf_pkg.sv
// ---------------------------------------------------------------------------
// c3sf_pkg
// Shared types and constants of the 3x3 cross smoothing filter.
// ---------------------------------------------------------------------------
package c3sf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // sizes in use after reset
    localparam int FRAME_WIDTH_RESET  = 80;
    localparam int FRAME_HEIGHT_RESET = 21;

    // smallest frame side the window can handle
    localparam int MIN_SIDE = 3;

    // weighted sum / 6 = (sum / 2) / 3, the / 3 as multiply by reciprocal
    localparam int         DIV3_SHIFT = 11;
    localparam logic [9:0] DIV3_RECIP = 10'd683;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // control of one word as it moves into the data stage
    typedef struct packed {
        logic pixel;      // real pixel: shifts window, updates line stores
        logic emit;       // a result leaves for this word
        logic border;     // result is the centre pixel passed through
        logic frame_end;  // result is the last pixel of the frame
        logic sel_lower;  // flush result comes from the lower line store
    } s1_ctrl_t;

endpackage

### sv/cross_3x3_smoothing_filter.sv
// ---------------------------------------------------------------------------
// cross_3x3_smoothing_filter
// Raster pixel stream smoother: two line stores and a cross shaped 3x3
// window, interior pixels weighted 2/1 (centre/arms) and divided by 6, borders passed.
// ---------------------------------------------------------------------------
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  pixel    | pixel_valid pixel_stall pixel_in flush | in
//  result   | result_valid result_stall pixel_out    | out
//           | frame_end                             |
//  config   | cfg_valid cfg_ready cfg_index cfg_data | in
//
//  One word per clock while pixel_stall is low: position control is decided
//  at accept, the line stores are read then and written back in the data stage.
//  A result is loaded into the output register when the data stage fires and
//  can be taken from there while result_valid is high.
//  Reset clears counters and the pipeline; line stores are not cleared.
//  pixel_stall rises only while the data stage holds a result and the
//  output register is full and stalled.
//  cfg_ready is always high; a width or height write restarts the frame position.
// ---------------------------------------------------------------------------
module cross_3x3_smoothing_filter #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic [c3sf_pkg::PIXEL_W-1:0]       pixel_in,
    input  logic                               flush,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [c3sf_pkg::PIXEL_W-1:0]       pixel_out,
    output logic                               frame_end,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [c3sf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [c3sf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import c3sf_pkg::*;

    function automatic int last_index(input int value, input int maxv);
        int v;
        begin
            v = value;
            if (v < MIN_SIDE)
                v = MIN_SIDE;
            if (v > maxv)
                v = maxv;
            return v - 1;
        end
    endfunction

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int COL_LAST_RESET = last_index(FRAME_WIDTH_RESET, MAX_WIDTH);
    localparam int ROW_LAST_RESET = last_index(FRAME_HEIGHT_RESET, MAX_HEIGHT);

    // frame size and positions
    logic [COL_W-1:0]   col_last_reg;
    logic [ROW_W-1:0]   row_last_reg;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic               primed_reg, primed_next;

    // data stage
    logic               s1_valid_reg;
    s1_ctrl_t           s1_ctrl_reg, s1_ctrl_next;
    logic [COL_W-1:0]   s1_addr_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic               s1_fire;

    // line stores
    logic [PIXEL_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] lower_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] upper_rd_reg, lower_rd_reg;
    logic [COL_W-1:0]   rd_addr;
    logic               fwd_hit_reg;
    logic [PIXEL_W-1:0] fwd_upper_reg, fwd_lower_reg;
    logic [PIXEL_W-1:0] upper_eff, lower_eff;

    // window taps that a later result still needs
    logic [PIXEL_W-1:0] top_right_reg, mid_centre_reg, mid_right_reg, bot_right_reg;

    // output register
    logic               result_valid_reg;
    logic [PIXEL_W-1:0] pixel_out_reg;
    logic               frame_end_reg;

    logic               accept;
    logic               cfg_we;
    logic [PIXEL_W+2:0] cross_sum;
    logic [19:0]        div_prod;
    logic [PIXEL_W-1:0] smooth_val;
    logic [PIXEL_W-1:0] result_val;

    assign cfg_ready   = 1'b1;
    assign cfg_we      = cfg_valid && cfg_ready;
    assign s1_fire     = s1_valid_reg &&
                         (!s1_ctrl_reg.emit || !result_valid_reg || !result_stall);
    assign pixel_stall = s1_valid_reg && !s1_fire;
    assign accept      = pixel_valid && !pixel_stall;

    // ---------------- position control, decided at accept ----------------
    always_comb
    begin
        logic [COL_W-1:0] exp_col;
        logic [ROW_W-1:0] exp_row;
        logic [COL_W-1:0] pos_col;
        logic [ROW_W-1:0] pos_row;
        logic             keep;
        logic             start;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        primed_next  = primed_reg;
        s1_ctrl_next = '0;
        rd_addr      = in_col_reg;
        exp_col      = '0;
        exp_row      = '0;
        keep         = 1'b0;
        start        = 1'b0;
        pos_col      = out_col_reg;
        pos_row      = out_row_reg;

        if (flush)
        begin
            rd_addr = out_col_reg;
            if (primed_reg && in_row_reg == '0 && in_col_reg == '0)
            begin
                s1_ctrl_next.emit      = 1'b1;
                s1_ctrl_next.border    = 1'b1;
                s1_ctrl_next.sel_lower = (out_row_reg == row_last_reg);
                s1_ctrl_next.frame_end = (out_row_reg == row_last_reg) &&
                                         (out_col_reg == col_last_reg);
                if (s1_ctrl_next.frame_end)
                begin
                    primed_next  = 1'b0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_reg == col_last_reg)
                begin
                    out_col_next = '0;
                    out_row_next = (out_row_reg == row_last_reg) ? '0
                                 : out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
        else
        begin
            s1_ctrl_next.pixel = 1'b1;

            // output must trail the input by one row plus one pixel
            if (in_col_reg != '0)
            begin
                exp_col = in_col_reg - COL_W'(1);
                exp_row = (in_row_reg == '0) ? row_last_reg : in_row_reg - ROW_W'(1);
            end
            else
            begin
                exp_col = col_last_reg;
                if (in_row_reg == '0)
                    exp_row = row_last_reg - ROW_W'(1);
                else if (in_row_reg == ROW_W'(1))
                    exp_row = row_last_reg;
                else
                    exp_row = in_row_reg - ROW_W'(2);
            end
            keep  = primed_reg && out_row_reg == exp_row && out_col_reg == exp_col;
            start = !keep && in_row_reg == ROW_W'(1) && in_col_reg == COL_W'(1);
            if (start)
            begin
                pos_col = '0;
                pos_row = '0;
            end
            primed_next = keep || start;

            if (keep || start)
            begin
                s1_ctrl_next.emit      = 1'b1;
                s1_ctrl_next.border    = pos_row == '0 || pos_row == row_last_reg ||
                                         pos_col == '0 || pos_col == col_last_reg;
                s1_ctrl_next.frame_end = pos_row == row_last_reg &&
                                         pos_col == col_last_reg;
                if (pos_col == col_last_reg)
                begin
                    out_col_next = '0;
                    out_row_next = (pos_row == row_last_reg) ? '0 : pos_row + ROW_W'(1);
                end
                else
                begin
                    out_col_next = pos_col + COL_W'(1);
                    out_row_next = pos_row;
                end
            end

            if (in_col_reg == col_last_reg)
            begin
                in_col_next = '0;
                in_row_next = (in_row_reg == row_last_reg) ? '0
                            : in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= COL_W'(COL_LAST_RESET);
            row_last_reg <= ROW_W'(ROW_LAST_RESET);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            primed_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:
                begin
                    col_last_reg <= COL_W'(last_index(int'(cfg_data), MAX_WIDTH));
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    primed_reg   <= 1'b0;
                end
                REG_FRAME_HEIGHT:
                begin
                    row_last_reg <= ROW_W'(last_index(int'(cfg_data), MAX_HEIGHT));
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    primed_reg   <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            primed_reg  <= primed_next;
        end
    end

    // ---------------- data stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_ctrl_reg  <= s1_ctrl_next;
            // the read at this edge misses a write-back landing at the same edge
            fwd_hit_reg  <= s1_fire && s1_ctrl_reg.pixel && s1_addr_reg == rd_addr;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= rd_addr;
            s1_pix_reg    <= pixel_in;
            upper_rd_reg  <= upper_mem[rd_addr];
            lower_rd_reg  <= lower_mem[rd_addr];
            fwd_upper_reg <= lower_eff;
            fwd_lower_reg <= s1_pix_reg;
        end
        if (s1_fire && s1_ctrl_reg.pixel)
        begin
            upper_mem[s1_addr_reg] <= lower_eff;
            lower_mem[s1_addr_reg] <= s1_pix_reg;
        end
    end

    assign upper_eff = fwd_hit_reg ? fwd_upper_reg : upper_rd_reg;
    assign lower_eff = fwd_hit_reg ? fwd_lower_reg : lower_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_right_reg  <= '0;
            mid_centre_reg <= '0;
            mid_right_reg  <= '0;
            bot_right_reg  <= '0;
        end
        else if (s1_fire && s1_ctrl_reg.pixel)
        begin
            top_right_reg  <= upper_eff;
            mid_centre_reg <= mid_right_reg;
            mid_right_reg  <= lower_eff;
            bot_right_reg  <= s1_pix_reg;
        end
    end

    // after the shift: up = top_right, down = bot_right, left = mid_centre,
    // centre = mid_right, right = lower store read
    assign cross_sum = {2'b00, mid_right_reg, 1'b0}
                     + (PIXEL_W+3)'(top_right_reg)
                     + (PIXEL_W+3)'(bot_right_reg)
                     + (PIXEL_W+3)'(mid_centre_reg)
                     + (PIXEL_W+3)'(lower_eff);
    assign div_prod   = 20'(cross_sum[PIXEL_W+2:1]) * 20'(DIV3_RECIP);
    assign smooth_val = div_prod[DIV3_SHIFT +: PIXEL_W];

    always_comb
    begin
        if (!s1_ctrl_reg.pixel)
            result_val = s1_ctrl_reg.sel_lower ? lower_eff : upper_eff;
        else if (s1_ctrl_reg.border)
            result_val = mid_right_reg;
        else
            result_val = smooth_val;
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (s1_fire && s1_ctrl_reg.emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctrl_reg.emit)
        begin
            pixel_out_reg <= result_val;
            frame_end_reg <= s1_ctrl_reg.frame_end;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign frame_end    = frame_end_reg;

    // ---------------- assertions ----------------
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (result_valid_reg && result_stall))
        else $error("input stalled without a blocked result");

    a_flush_end_unprimes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we && flush && s1_ctrl_next.emit && s1_ctrl_next.frame_end)
        |=> !primed_reg)
        else $error("frame end by flush left the filter primed");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_col_reg <= col_last_reg) && (out_col_reg <= col_last_reg))
        else $error("column position beyond frame width");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_fire && s1_ctrl_reg.pixel && s1_addr_reg == rd_addr)
        |=> fwd_hit_reg)
        else $error("same-entry write-back not forwarded");

endmodule
